// ===== hw/rtl/max_pool_window_argmax_defines.svh =====
// Assertion macros for the max pooling block.
// Used by the top level only; needs clock and reset in scope.
`ifndef MAX_POOL_WINDOW_ARGMAX_DEFINES_SVH
`define MAX_POOL_WINDOW_ARGMAX_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define MPWA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MPWA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mpwa_pkg.sv =====
// Shared types and constants for the max pooling block.
// No dependencies; used by every module of the block but mpwa_ram.
`timescale 1ns / 1ps

package mpwa_pkg;

   localparam int MAX_ROWS_DEF   = 64;
   localparam int MAX_COLS_DEF   = 64;
   localparam int MAX_WINDOW_DEF = 8;

   localparam int VALUE_W = 16;
   localparam int POS_W   = 12;  // signed window position, covers padding and far requests

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_POOL  = 1'b1;

   typedef enum logic [2:0] {
      REG_IN_ROWS     = 3'd0,
      REG_IN_COLS     = 3'd1,
      REG_PAD_TOP     = 3'd2,
      REG_PAD_LEFT    = 3'd3,
      REG_WINDOW_ROWS = 3'd4,
      REG_WINDOW_COLS = 3'd5,
      REG_STRIDE_ROWS = 3'd6,
      REG_STRIDE_COLS = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [6:0] in_rows;
      logic [6:0] in_cols;
      logic [2:0] pad_top;
      logic [2:0] pad_left;
      logic [3:0] window_rows;
      logic [3:0] window_cols;
      logic [3:0] stride_rows;
      logic [3:0] stride_cols;
   } cfg_type;

   // One window position on its way from the scanner to the compare stage.
   typedef struct packed {
      logic                    valid;
      logic                    first;
      logic                    last;
      logic                    pad;
      logic signed [POS_W-1:0] row;
      logic signed [POS_W-1:0] col;
   } tap_type;

endpackage

// ===== hw/rtl/mpwa_ram.sv =====
// Generic simple dual-port RAM with one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mpwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mpwa_scan.sv =====
// Window scanner: walks one pooling window row by row and issues store reads.
// Depends on mpwa_pkg.
`timescale 1ns / 1ps

module mpwa_scan #(
   parameter int MAX_ROWS   = mpwa_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = mpwa_pkg::MAX_COLS_DEF,
   parameter int MAX_WINDOW = mpwa_pkg::MAX_WINDOW_DEF,
   parameter int AW         = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [5:0]        row,
   input  logic [5:0]        col,
   input  mpwa_pkg::cfg_type cfg,
   output logic              busy,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   output mpwa_pkg::tap_type tap
);

   localparam int WCW = $clog2(MAX_WINDOW + 1);
   localparam int PW  = mpwa_pkg::POS_W;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [WCW-1:0]     ki_ff, ki_in, kj_ff, kj_in;
   logic signed [PW-1:0] r0_ff, r0_in, c0_ff, c0_in;
   mpwa_pkg::tap_type  tap_ff, tap_in;

   logic [WCW-1:0]     win_rows, win_cols;
   logic [6:0]         rows_eff, cols_eff;
   logic signed [PW-1:0] r_pos, c_pos;
   logic               in_plane, row_end, col_end;

   always_comb begin
      if (cfg.window_rows == 4'd0) begin
         win_rows = WCW'(1);
      end else if (int'(cfg.window_rows) > MAX_WINDOW) begin
         win_rows = WCW'(MAX_WINDOW);
      end else begin
         win_rows = WCW'(cfg.window_rows);
      end
      if (cfg.window_cols == 4'd0) begin
         win_cols = WCW'(1);
      end else if (int'(cfg.window_cols) > MAX_WINDOW) begin
         win_cols = WCW'(MAX_WINDOW);
      end else begin
         win_cols = WCW'(cfg.window_cols);
      end
      rows_eff = (int'(cfg.in_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg.in_rows;
      cols_eff = (int'(cfg.in_cols) > MAX_COLS) ? 7'(MAX_COLS) : cfg.in_cols;
   end

   assign r_pos    = r0_ff + $signed(PW'(ki_ff));
   assign c_pos    = c0_ff + $signed(PW'(kj_ff));
   assign in_plane = !r_pos[PW-1] && !c_pos[PW-1]
                     && (r_pos < $signed(PW'(rows_eff)))
                     && (c_pos < $signed(PW'(cols_eff)));
   assign col_end  = (kj_ff == win_cols - WCW'(1));
   assign row_end  = (ki_ff == win_rows - WCW'(1));

   assign rd_en   = (state_ff == ST_SCAN) && in_plane;
   assign rd_addr = AW'(int'(r_pos[PW-2:0]) * MAX_COLS + int'(c_pos[PW-2:0]));

   always_comb begin
      state_in = state_ff;
      ki_in    = ki_ff;
      kj_in    = kj_ff;
      r0_in    = r0_ff;
      c0_in    = c0_ff;
      tap_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               r0_in    = $signed(PW'(10'(row) * 10'(cfg.stride_rows)))
                          - $signed(PW'(cfg.pad_top));
               c0_in    = $signed(PW'(10'(col) * 10'(cfg.stride_cols)))
                          - $signed(PW'(cfg.pad_left));
               ki_in    = '0;
               kj_in    = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tap_in.valid = 1'b1;
            tap_in.first = (ki_ff == '0) && (kj_ff == '0);
            tap_in.last  = row_end && col_end;
            tap_in.pad   = !in_plane;
            tap_in.row   = r_pos;
            tap_in.col   = c_pos;
            if (col_end) begin
               kj_in = '0;
               ki_in = ki_ff + WCW'(1);
               if (row_end) begin
                  state_in = ST_IDLE;
               end
            end else begin
               kj_in = kj_ff + WCW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
      ki_ff <= ki_in;
      kj_ff <= kj_in;
      r0_ff <= r0_in;
      c0_ff <= c0_in;
   end

   // Tap is registered so it lines up with the registered store read data.
   assign tap  = tap_ff;
   assign busy = (state_ff == ST_SCAN);

endmodule

// ===== hw/rtl/mpwa_argmax.sv =====
// Running maximum with first-position tie break over the scanned window.
// Depends on mpwa_pkg.
`timescale 1ns / 1ps

module mpwa_argmax (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mpwa_pkg::tap_type                     tap,
   input  logic signed [mpwa_pkg::VALUE_W-1:0]   rd_data,
   output logic                                  rsp_valid,
   output logic signed [mpwa_pkg::VALUE_W-1:0]   max_value,
   output logic signed [7:0]                     max_row,
   output logic signed [7:0]                     max_col
);

   localparam int VW = mpwa_pkg::VALUE_W;
   localparam int PW = mpwa_pkg::POS_W;

   logic signed [VW-1:0] best_ff, best_in, sample;
   logic signed [PW-1:0] best_r_ff, best_r_in, best_c_ff, best_c_in;
   logic                 rsp_valid_ff;
   logic signed [VW-1:0] rsp_value_ff;
   logic signed [7:0]    rsp_row_ff, rsp_col_ff;
   logic                 take;

   assign sample = tap.pad ? '0 : rd_data;
   // After the first tap only a strictly greater value replaces the maximum.
   assign take   = tap.valid && (tap.first || (sample > best_ff));

   always_comb begin
      best_in   = best_ff;
      best_r_in = best_r_ff;
      best_c_in = best_c_ff;
      if (take) begin
         best_in   = sample;
         best_r_in = tap.row;
         best_c_in = tap.col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tap.valid && tap.last;
      end
      best_ff   <= best_in;
      best_r_ff <= best_r_in;
      best_c_ff <= best_c_in;
      if (tap.valid && tap.last) begin
         rsp_value_ff <= best_in;
         rsp_row_ff   <= best_r_in[7:0];
         rsp_col_ff   <= best_c_in[7:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign max_value = rsp_value_ff;
   assign max_row   = rsp_row_ff;
   assign max_col   = rsp_col_ff;

endmodule

// ===== hw/rtl/max_pool_window_argmax.sv =====
// Max pooling with argmax over one stored plane. A write request stores its value
// when accepted. A pool request scans one window position per cycle, reading the
// store inside the plane; busy holds through the scan and the last tap, and the
// result strobes after it. Results cannot be stalled. Synchronous reset restores
// the control and config registers to defaults; the plane store is not cleared.
`timescale 1ns / 1ps
`include "max_pool_window_argmax_defines.svh"

module max_pool_window_argmax #(
   parameter int MAX_ROWS   = mpwa_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = mpwa_pkg::MAX_COLS_DEF,
   parameter int MAX_WINDOW = mpwa_pkg::MAX_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [5:0]                          req_row,
   input  logic [5:0]                          req_col,
   input  logic signed [mpwa_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   output logic signed [mpwa_pkg::VALUE_W-1:0] rsp_max_value,
   output logic signed [7:0]                   rsp_max_row,
   output logic signed [7:0]                   rsp_max_col,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [6:0]                          csr_data
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   mpwa_pkg::cfg_type cfg_ff, cfg_in;
   mpwa_pkg::tap_type tap;
   logic              accept, pool_start, scan_busy;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic signed [mpwa_pkg::VALUE_W-1:0] rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (mpwa_pkg::reg_index_type'(csr_index))
            mpwa_pkg::REG_IN_ROWS:     cfg_in.in_rows     = csr_data;
            mpwa_pkg::REG_IN_COLS:     cfg_in.in_cols     = csr_data;
            mpwa_pkg::REG_PAD_TOP:     cfg_in.pad_top     = csr_data[2:0];
            mpwa_pkg::REG_PAD_LEFT:    cfg_in.pad_left    = csr_data[2:0];
            mpwa_pkg::REG_WINDOW_ROWS: cfg_in.window_rows = csr_data[3:0];
            mpwa_pkg::REG_WINDOW_COLS: cfg_in.window_cols = csr_data[3:0];
            mpwa_pkg::REG_STRIDE_ROWS: cfg_in.stride_rows = csr_data[3:0];
            mpwa_pkg::REG_STRIDE_COLS: cfg_in.stride_cols = csr_data[3:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_rows     <= 7'd64;
         cfg_ff.in_cols     <= 7'd64;
         cfg_ff.pad_top     <= 3'd0;
         cfg_ff.pad_left    <= 3'd0;
         cfg_ff.window_rows <= 4'd2;
         cfg_ff.window_cols <= 4'd2;
         cfg_ff.stride_rows <= 4'd2;
         cfg_ff.stride_cols <= 4'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept     = start && !busy;
   assign pool_start = accept && (req_operation == mpwa_pkg::OP_POOL);
   // Drop writes that fall outside the store.
   assign wr_en      = accept && (req_operation == mpwa_pkg::OP_WRITE)
                       && (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLS);
   assign wr_addr    = AW'(int'(req_row) * MAX_COLS + int'(req_col));
   assign busy       = scan_busy || tap.valid;

   mpwa_ram #(
      .WIDTH (mpwa_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_plane (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpwa_scan #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_WINDOW (MAX_WINDOW),
      .AW         (AW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (pool_start),
      .row     (req_row),
      .col     (req_col),
      .cfg     (cfg_ff),
      .busy    (scan_busy),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .tap     (tap)
   );

   mpwa_argmax u_argmax (
      .clock     (clock),
      .reset     (reset),
      .tap       (tap),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .max_value (rsp_max_value),
      .max_row   (rsp_max_row),
      .max_col   (rsp_max_col)
   );

   `MPWA_ASSERT_NEXT(a_last_gives_rsp, tap.valid && tap.last, rsp_valid, "missing response")
   `MPWA_ASSERT_NEXT(a_pool_holds_busy, pool_start, busy, "pool request not held busy")
   `MPWA_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy, "response while scan active")
   `MPWA_ASSERT_SAME(a_no_rw_overlap, wr_en, !rd_en, "store write during scan read")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for max_pool_window_argmax: plane writes, pooled window
// requests and register setups, checked against typed results or an in-bench window
// scan. Depends on mpwa_pkg and the max_pool_window_argmax RTL.
`timescale 1ns / 1ps

module testbench;
   import mpwa_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = MAX_WINDOW_DEF * MAX_WINDOW_DEF + 6;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 150;

   typedef struct packed {
      logic signed [15:0] max_value;
      logic signed [7:0]  max_row;
      logic signed [7:0]  max_col;
   } pooled_t;

   typedef enum logic {STEP_REQUEST, STEP_CSR} step_kind_t;

   typedef struct packed {
      step_kind_t    kind;
      logic          op;
      reg_index_type csr;
      logic [5:0]    row;
      logic [5:0]    col;
      logic [15:0]   data;
      logic          typed;
      pooled_t       result;
   } step_t;

   localparam pooled_t NO_RESULT = '0;

   // Directed requests; typed rows carry the result read straight off the window.
   localparam step_t DIRECTED_STEPS [34] = '{
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd0,  6'd0,  16'h7FFF, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd0,  6'd1,  16'h8000, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd1,  6'd0,  16'h0000, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd1,  6'd1,  16'hFFFF, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd0,  6'd0,  16'h0000, 1'b1,
        '{16'sh7FFF, 8'sd0, 8'sd0}},
      // all-minimum window reports its first position
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd0,  6'd2,  16'h8000, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd0,  6'd3,  16'h8000, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd1,  6'd2,  16'h8000, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd1,  6'd3,  16'h8000, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd0,  6'd1,  16'hFFFF, 1'b1,
        '{16'sh8000, 8'sd0, 8'sd2}},
      // ties keep the earliest maximum
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd2,  6'd0,  16'hFF00, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd2,  6'd1,  16'h0100, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd3,  6'd0,  16'h0100, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd3,  6'd1,  16'h0100, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd1,  6'd0,  16'h0000, 1'b1,
        '{16'sh0100, 8'sd2, 8'sd1}},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd62, 6'd62, 16'h8001, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd62, 6'd63, 16'h8001, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd63, 6'd62, 16'h8001, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_WRITE, REG_IN_ROWS, 6'd63, 6'd63, 16'h1234, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd31, 6'd31, 16'h0000, 1'b1,
        '{16'sh1234, 8'sd63, 8'sd63}},
      // window entirely past the plane
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd63, 6'd63, 16'h0000, 1'b1,
        '{16'sh0000, 8'sd126, 8'sd126}},
      // empty plane: everything is padding
      '{STEP_CSR,     OP_WRITE, REG_IN_ROWS, 6'd0,  6'd0,  16'h0000, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd0,  6'd0,  16'h0000, 1'b1,
        '{16'sh0000, 8'sd0, 8'sd0}},
      // oversize plane, full padding on top and left
      '{STEP_CSR,     OP_WRITE, REG_IN_ROWS, 6'd0,  6'd0,  16'h007F, 1'b0, NO_RESULT},
      '{STEP_CSR,     OP_WRITE, REG_PAD_TOP, 6'd0,  6'd0,  16'h007F, 1'b0, NO_RESULT},
      '{STEP_CSR,     OP_WRITE, REG_PAD_LEFT, 6'd0, 6'd0,  16'h007F, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd0,  6'd0,  16'h0000, 1'b1,
        '{16'sh0000, -8'sd7, -8'sd7}},
      // zero-height window acts as one row, oversize width as the maximum, zero stride
      '{STEP_CSR,     OP_WRITE, REG_WINDOW_ROWS, 6'd0, 6'd0, 16'h0000, 1'b0, NO_RESULT},
      '{STEP_CSR,     OP_WRITE, REG_WINDOW_COLS, 6'd0, 6'd0, 16'h007F, 1'b0, NO_RESULT},
      '{STEP_CSR,     OP_WRITE, REG_STRIDE_ROWS, 6'd0, 6'd0, 16'h0000, 1'b0, NO_RESULT},
      '{STEP_CSR,     OP_WRITE, REG_STRIDE_COLS, 6'd0, 6'd0, 16'h007F, 1'b0, NO_RESULT},
      '{STEP_CSR,     OP_WRITE, REG_PAD_TOP, 6'd0,  6'd0,  16'h0078, 1'b0, NO_RESULT},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd40, 6'd0,  16'h0000, 1'b1,
        '{16'sh7FFF, 8'sd0, 8'sd0}},
      '{STEP_REQUEST, OP_POOL,  REG_IN_ROWS, 6'd9,  6'd0,  16'h5A5A, 1'b0, NO_RESULT}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_operation = OP_WRITE;
   logic [5:0]         req_row = '0;
   logic [5:0]         req_col = '0;
   logic signed [15:0] req_value = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_max_value;
   logic signed [7:0]  rsp_max_row;
   logic signed [7:0]  rsp_max_col;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   reg_index_type      csr_index = REG_IN_ROWS;
   logic [6:0]         csr_data = '0;

   cfg_type            plane_cfg;
   logic signed [15:0] plane [0:4095];
   bit                 written [0:4095];
   pooled_t            expected_pools [$];
   int                 sender_idle_pct = 0;
   int                 requests_sent = 0;
   int                 mismatches = 0;
   int                 cycle_count = 0;

   max_pool_window_argmax dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_max_value (rsp_max_value),
      .rsp_max_row   (rsp_max_row),
      .rsp_max_col   (rsp_max_col),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int plane_extent(input logic [6:0] size);
      return (size > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(size);
   endfunction

   function automatic int clamp_window(input logic [3:0] size);
      if (size == 0) return 1;
      return (size > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(size);
   endfunction

   // Scan row by row; past the first, only a strictly greater value moves the maximum.
   function automatic pooled_t predict_pool(input logic [5:0] out_row, input logic [5:0] out_col);
      int      rows, cols, r0, c0, r, c, i, j, v, best;
      bit      have;
      pooled_t res;
      rows = plane_extent(plane_cfg.in_rows);
      cols = plane_extent(plane_cfg.in_cols);
      r0   = int'(out_row) * int'(plane_cfg.stride_rows) - int'(plane_cfg.pad_top);
      c0   = int'(out_col) * int'(plane_cfg.stride_cols) - int'(plane_cfg.pad_left);
      have = 1'b0;
      best = 0;
      res  = '0;
      for (i = 0; i < clamp_window(plane_cfg.window_rows); i++) begin
         for (j = 0; j < clamp_window(plane_cfg.window_cols); j++) begin
            r = r0 + i;
            c = c0 + j;
            if (r < 0 || c < 0 || r >= rows || c >= cols) v = 0;
            else v = int'(plane[r * MAX_COLS_DEF + c]);
            if (!have || v > best) begin
               have          = 1'b1;
               best          = v;
               res.max_value = best[15:0];
               res.max_row   = r[7:0];
               res.max_col   = c[7:0];
            end
         end
      end
      return res;
   endfunction

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3: return 16'($urandom_range(0, 8)) - 16'd4;  // crowd values to force ties
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [6:0] pick_extent();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'($urandom_range(64, 127));
         2: return 7'($urandom_range(13, 63));
         default: return 7'($urandom_range(1, 12));
      endcase
   endfunction

   // Window size or stride, upper data bits random since the register drops them.
   function automatic logic [6:0] pick_step(input int common_hi);
      logic [3:0] s;
      case ($urandom_range(0, 9))
         0: s = 4'd0;
         1: s = 4'($urandom_range(8, 15));
         default: s = 4'($urandom_range(1, common_hi));
      endcase
      return {3'($urandom), s};
   endfunction

   function automatic logic [5:0] pick_out_index(input logic [3:0] stride, input int reach);
      int hi;
      if (stride == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      hi = reach / int'(stride);
      return 6'($urandom_range(0, (hi > 63) ? 63 : hi));
   endfunction

   // Drive one request and hold it until accepted; start stays high on return.
   task automatic send_request(input logic op, input logic [5:0] r, input logic [5:0] c,
                               input logic signed [15:0] v, input logic use_typed,
                               input pooled_t typed_result);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_row       <= r;
      req_col       <= c;
      req_value     <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
      if (op == OP_WRITE) begin
         plane[{r, c}]   = v;
         written[{r, c}] = 1'b1;
      end else if (use_typed) begin
         expected_pools.push_back(typed_result);
      end else begin
         expected_pools.push_back(predict_pool(r, c));
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_pools.size() != 0) @(negedge clock);
   endtask

   // A trailing write may still be in flight after the last result.
   task automatic quiesce();
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Leaves csr_valid high so back-to-back writes never drop it.
   task automatic write_register(input reg_index_type idx, input logic [6:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_IN_ROWS:     plane_cfg.in_rows     = data;
         REG_IN_COLS:     plane_cfg.in_cols     = data;
         REG_PAD_TOP:     plane_cfg.pad_top     = data[2:0];
         REG_PAD_LEFT:    plane_cfg.pad_left    = data[2:0];
         REG_WINDOW_ROWS: plane_cfg.window_rows = data[3:0];
         REG_WINDOW_COLS: plane_cfg.window_cols = data[3:0];
         REG_STRIDE_ROWS: plane_cfg.stride_rows = data[3:0];
         REG_STRIDE_COLS: plane_cfg.stride_cols = data[3:0];
      endcase
   endtask

   task automatic program_plane(input logic [6:0] settings [8]);
      int idx;
      quiesce();
      for (idx = 0; idx < 8; idx++) write_register(reg_index_type'(idx), settings[idx]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Write every unwritten in-plane position of the window, then request the pool.
   task automatic pool_with_fill();
      logic [5:0] out_row, out_col;
      int         rows, cols, r0, c0, r, c, i, j;
      rows    = plane_extent(plane_cfg.in_rows);
      cols    = plane_extent(plane_cfg.in_cols);
      out_row = pick_out_index(plane_cfg.stride_rows, rows + int'(plane_cfg.pad_top));
      out_col = pick_out_index(plane_cfg.stride_cols, cols + int'(plane_cfg.pad_left));
      r0      = int'(out_row) * int'(plane_cfg.stride_rows) - int'(plane_cfg.pad_top);
      c0      = int'(out_col) * int'(plane_cfg.stride_cols) - int'(plane_cfg.pad_left);
      for (i = 0; i < clamp_window(plane_cfg.window_rows); i++) begin
         for (j = 0; j < clamp_window(plane_cfg.window_cols); j++) begin
            r = r0 + i;
            c = c0 + j;
            if (r >= 0 && c >= 0 && r < rows && c < cols && !written[r * MAX_COLS_DEF + c])
               send_request(OP_WRITE, 6'(r), 6'(c), pick_value(), 1'b0, NO_RESULT);
         end
      end
      send_request(OP_POOL, out_row, out_col, 16'($urandom), 1'b0, NO_RESULT);
   endtask

   always @(posedge clock) begin : check_results
      pooled_t seen, want;
      if (!reset && rsp_valid) begin
         seen.max_value = rsp_max_value;
         seen.max_row   = rsp_max_row;
         seen.max_col   = rsp_max_col;
         if (expected_pools.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with no request pending: value %0d row %0d col %0d",
                        $realtime, seen.max_value, seen.max_row, seen.max_col);
         end else begin
            want = expected_pools.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: expected value %0d row %0d col %0d, got value %0d row %0d col %0d",
                           $realtime, want.max_value, want.max_row, want.max_col,
                           seen.max_value, seen.max_row, seen.max_col);
            end
         end
      end
   end

   initial begin : stimulus
      int         step, phase, phase_end, pick;
      logic [6:0] settings [8];
      plane_cfg = '{in_rows: 7'd64, in_cols: 7'd64, pad_top: 3'd0, pad_left: 3'd0,
                    window_rows: 4'd2, window_cols: 4'd2, stride_rows: 4'd2, stride_cols: 4'd2};
      while (reset) @(negedge clock);

      for (step = 0; step < $size(DIRECTED_STEPS); step++) begin
         if (DIRECTED_STEPS[step].kind == STEP_CSR) begin
            if (step == 0 || DIRECTED_STEPS[step - 1].kind != STEP_CSR) quiesce();
            write_register(DIRECTED_STEPS[step].csr, DIRECTED_STEPS[step].data[6:0]);
            if (step == $size(DIRECTED_STEPS) - 1 || DIRECTED_STEPS[step + 1].kind != STEP_CSR)
            begin
               @(negedge clock);
               csr_valid <= 1'b0;
            end
         end else begin
            send_request(DIRECTED_STEPS[step].op, DIRECTED_STEPS[step].row,
                         DIRECTED_STEPS[step].col, DIRECTED_STEPS[step].data,
                         DIRECTED_STEPS[step].typed, DIRECTED_STEPS[step].result);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            settings = '{default: 7'h7F};
         end else if (phase == 1) begin
            settings = '{7'd1, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
         end else begin
            settings[REG_IN_ROWS]     = pick_extent();
            settings[REG_IN_COLS]     = pick_extent();
            settings[REG_PAD_TOP]     = 7'($urandom);
            settings[REG_PAD_LEFT]    = 7'($urandom);
            settings[REG_WINDOW_ROWS] = pick_step(3);
            settings[REG_WINDOW_COLS] = pick_step(3);
            settings[REG_STRIDE_ROWS] = pick_step(4);
            settings[REG_STRIDE_COLS] = pick_step(4);
         end
         program_plane(settings);
         sender_idle_pct = (phase % 3 == 1) ? 86 : (phase % 3 == 2) ? 26 : 0;
         phase_end = requests_sent + ITEMS_PER_PHASE;
         while (requests_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) drain_results();
            else if (pick < 30)
               send_request(OP_WRITE, 6'($urandom), 6'($urandom), pick_value(), 1'b0, NO_RESULT);
            else pool_with_fill();
         end
      end

      quiesce();
      if (mismatches == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mpwa_pkg.sv
hw/rtl/mpwa_ram.sv
hw/rtl/mpwa_scan.sv
hw/rtl/mpwa_argmax.sv
hw/rtl/max_pool_window_argmax.sv
test/testbench.sv
